>>> sv/iul_pkg.sv
// package with shared constants and types for the interval union length block
`timescale 1ns / 1ps
package iul_pkg;

  localparam int MAX_INTERVALS_DEF = 1024;
  localparam int COORD_BITS_DEF    = 31;
  localparam int LEN_BITS          = 31;
  localparam int QUEUE_DEPTH       = 2;

  // back end sequencer states
  typedef enum logic [3:0] {
    B_IDLE,
    B_BLK,
    B_LDA,
    B_LDB,
    B_CAPB,
    B_MERGE,
    B_WAITA,
    B_WAITB,
    B_SWRD,
    B_SWEX,
    B_OUT
  } back_state_t;

endpackage

>>> sv/iul_if.sv
// channel interfaces for interval input and result output
`timescale 1ns / 1ps
interface iul_in_if #(
  parameter int COORD_BITS = iul_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] left_end;
  logic [COORD_BITS-1:0] right_end;
  logic                  is_last;
  modport source (output valid, left_end, right_end, is_last, input ready);
  modport sink (input valid, left_end, right_end, is_last, output ready);
endinterface

interface iul_out_if;
  logic                          valid;
  logic                          ready;
  logic [iul_pkg::LEN_BITS-1:0]  union_length;
  logic                          set_overflow;
  modport source (output valid, union_length, set_overflow, input ready);
  modport sink (input valid, union_length, set_overflow, output ready);
endinterface

>>> sv/interval_union_length_top.sv
// top level of the interval union length block
`timescale 1ns / 1ps
// Intervals are taken one per cycle and written into bank 0 of a two-bank
// store; the transaction flagged is_last closes the set and the input then
// stalls until the result is registered. The set is sorted by left coordinate
// with a bottom-up merge sort that ping-pongs between the banks: each merged
// block first loads its two run heads one after the other, because the single
// read port of a bank fetches one run head at a time, and there are
// ceil(log2(n)) passes. The sweep then reads the sorted intervals in order
// and sums the covered length. Intervals past MAX_INTERVALS are dropped and
// flagged in set_overflow. The output register lets the next set load while
// a result waits. No clearing pass after reset is needed.
module interval_union_length_top #(
  parameter int MAX_INTERVALS = iul_pkg::MAX_INTERVALS_DEF,
  parameter int COORD_BITS    = iul_pkg::COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  iul_in_if.sink    in_chan,
  iul_out_if.source out_chan
);
  localparam int AW    = $clog2(MAX_INTERVALS);
  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam int DW    = 2 * COORD_BITS;

  logic          f_we, b_we, q_push, q_pop, q_not_full, q_not_empty, src, done;
  logic [AW-1:0] f_waddr, b_waddr, b_raddr, m0_waddr;
  logic [DW-1:0] f_wdata, b_wdata, m0_wdata, m0_rdata, m1_rdata;
  logic          m0_we, m1_we;
  logic [CNT_W:0] q_in, q_out;

  iul_front #(.MAX_INTERVALS(MAX_INTERVALS), .COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .wr_en      (f_we),
    .wr_addr    (f_waddr),
    .wr_data    (f_wdata),
    .q_push     (q_push),
    .q_data     (q_in),
    .q_not_full (q_not_full),
    .set_done   (done)
  );

  iul_queue #(.WIDTH(CNT_W + 1)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_not_empty)
  );

  iul_back #(.MAX_INTERVALS(MAX_INTERVALS), .COORD_BITS(COORD_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .rd_addr     (b_raddr),
    .rd_data     (src ? m1_rdata : m0_rdata),
    .src_bank    (src),
    .wr_en       (b_we),
    .wr_addr     (b_waddr),
    .wr_data     (b_wdata),
    .set_done    (done),
    .out_chan    (out_chan)
  );

  // bank 0 is shared by loading and by the merge passes that target it
  assign m0_we    = f_we || (b_we && src);
  assign m0_waddr = f_we ? f_waddr : b_waddr;
  assign m0_wdata = f_we ? f_wdata : b_wdata;
  assign m1_we    = b_we && !src;

  iul_ram #(.WIDTH(DW), .DEPTH(MAX_INTERVALS)) u_bank0 (
    .clk   (clk),
    .we    (m0_we),
    .waddr (m0_waddr),
    .wdata (m0_wdata),
    .raddr (b_raddr),
    .rdata (m0_rdata)
  );

  iul_ram #(.WIDTH(DW), .DEPTH(MAX_INTERVALS)) u_bank1 (
    .clk   (clk),
    .we    (m1_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (m1_rdata)
  );
endmodule

>>> sv/iul_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module iul_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/iul_queue.sv
// short fifo carrying set descriptors from front end to back end
`timescale 1ns / 1ps
module iul_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);
  localparam int PW = $clog2(iul_pkg::QUEUE_DEPTH);

  logic [WIDTH-1:0] slot_r [iul_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;

  assign not_full  = (cnt_r != (PW+1)'(iul_pkg::QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = slot_r[rp_r];

  // pointer and count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push && not_full) begin
      wp_nxt = wp_r + 1'b1;
    end
    if (pop && not_empty) begin
      rp_nxt = rp_r + 1'b1;
    end
    if ((push && not_full) && !(pop && not_empty)) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!(push && not_full) && (pop && not_empty)) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push && not_full) begin
      slot_r[wp_r] <= push_data;
    end
  end
endmodule

>>> sv/iul_front.sv
// front end: accepts intervals, writes them into the store, closes each set
`timescale 1ns / 1ps
module iul_front #(
  parameter int MAX_INTERVALS = iul_pkg::MAX_INTERVALS_DEF,
  parameter int COORD_BITS    = iul_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  iul_in_if.sink                           in_chan,
  output logic                             wr_en,
  output logic [$clog2(MAX_INTERVALS)-1:0] wr_addr,
  output logic [2*COORD_BITS-1:0]          wr_data,
  output logic                             q_push,
  output logic [$clog2(MAX_INTERVALS+1):0] q_data,
  input  logic                             q_not_full,
  input  logic                             set_done
);
  localparam int AW    = $clog2(MAX_INTERVALS);
  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

  logic             hold_r, hold_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             accept, room;
  logic [CNT_W-1:0] count_inc;

  assign in_chan.ready = !hold_r && q_not_full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign room          = (count_r < CNT_W'(MAX_INTERVALS));
  assign count_inc     = room ? count_r + 1'b1 : count_r;

  // store write
  assign wr_en   = accept && room;
  assign wr_addr = count_r[AW-1:0];
  assign wr_data = {in_chan.left_end, in_chan.right_end};

  // descriptor of a finished set
  assign q_push = accept && in_chan.is_last;
  assign q_data = {ovf_r || !room, count_inc};

  // count, overflow and hold until back end is done with the store
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    hold_nxt  = hold_r;
    if (set_done) begin
      hold_nxt = 1'b0;
    end
    if (accept) begin
      if (in_chan.is_last) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
        hold_nxt  = 1'b1;
      end else begin
        count_nxt = count_inc;
        ovf_nxt   = ovf_r || !room;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r  <= 1'b0;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      hold_r  <= hold_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end
endmodule

>>> sv/iul_back.sv
// back end: bottom-up merge sort over two banks, then sweep and result register
`timescale 1ns / 1ps
module iul_back #(
  parameter int MAX_INTERVALS = iul_pkg::MAX_INTERVALS_DEF,
  parameter int COORD_BITS    = iul_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_not_empty,
  input  logic [$clog2(MAX_INTERVALS+1):0] q_data,
  output logic                             q_pop,
  output logic [$clog2(MAX_INTERVALS)-1:0] rd_addr,
  input  logic [2*COORD_BITS-1:0]          rd_data,
  output logic                             src_bank,
  output logic                             wr_en,
  output logic [$clog2(MAX_INTERVALS)-1:0] wr_addr,
  output logic [2*COORD_BITS-1:0]          wr_data,
  output logic                             set_done,
  iul_out_if.source                        out_chan
);
  localparam int AW    = $clog2(MAX_INTERVALS);
  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam int W2    = CNT_W + 2;
  localparam int C     = COORD_BITS;
  localparam int DW    = 2 * COORD_BITS;
  localparam int LB    = iul_pkg::LEN_BITS;

  iul_pkg::back_state_t state_r, state_nxt;

  logic [W2-1:0] n_r, n_nxt, run_r, run_nxt, base_r, base_nxt;
  logic [W2-1:0] mid_r, mid_nxt, end_r, end_nxt;
  logic [W2-1:0] a_r, a_nxt, b_r, b_nxt, k_r, k_nxt, i_r, i_nxt;
  logic [W2-1:0] raddr, t_mid, t_end, next_base;
  logic          src_r, src_nxt, ovf_r, ovf_nxt;
  logic [DW-1:0] head_a_r, head_a_nxt, head_b_r, head_b_nxt;
  logic [C-1:0]  cov_r, cov_nxt, lo, hi;
  logic [LB-1:0] sum_r, sum_nxt;
  logic          ha_v, hb_v, take_a;
  logic          out_valid_r, out_valid_nxt, out_ovf_r, out_ovf_nxt;
  logic [LB-1:0] out_len_r, out_len_nxt;

  assign ha_v      = (a_r < mid_r);
  assign hb_v      = (b_r < end_r);
  assign take_a    = ha_v && (!hb_v || (head_a_r[DW-1:C] <= head_b_r[DW-1:C]));
  assign t_mid     = base_r + run_r;
  assign t_end     = base_r + (run_r << 1);
  assign next_base = base_r + (run_r << 1);
  assign lo        = rd_data[DW-1:C];
  assign hi        = rd_data[C-1:0];

  assign rd_addr  = raddr[AW-1:0];
  assign src_bank = src_r;
  assign wr_addr  = k_r[AW-1:0];
  assign wr_data  = take_a ? head_a_r : head_b_r;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.union_length = out_len_r;
  assign out_chan.set_overflow = out_ovf_r;

  // sequencer: load heads, merge runs, sweep, hand off result
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    run_nxt       = run_r;
    base_nxt      = base_r;
    mid_nxt       = mid_r;
    end_nxt       = end_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    src_nxt       = src_r;
    ovf_nxt       = ovf_r;
    head_a_nxt    = head_a_r;
    head_b_nxt    = head_b_r;
    cov_nxt       = cov_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_len_nxt   = out_len_r;
    out_ovf_nxt   = out_ovf_r;
    raddr         = a_r;
    wr_en         = 1'b0;
    q_pop         = 1'b0;
    set_done      = 1'b0;
    case (state_r)
      iul_pkg::B_IDLE: begin
        if (q_not_empty) begin
          q_pop    = 1'b1;
          n_nxt    = W2'(q_data[CNT_W-1:0]);
          ovf_nxt  = q_data[CNT_W];
          run_nxt  = W2'(1);
          base_nxt = '0;
          src_nxt  = 1'b0;
          i_nxt    = '0;
          cov_nxt  = '0;
          sum_nxt  = '0;
          state_nxt = (q_data[CNT_W-1:0] > CNT_W'(1)) ? iul_pkg::B_BLK : iul_pkg::B_SWRD;
        end
      end
      iul_pkg::B_BLK: begin
        mid_nxt   = (t_mid < n_r) ? t_mid : n_r;
        end_nxt   = (t_end < n_r) ? t_end : n_r;
        a_nxt     = base_r;
        b_nxt     = (t_mid < n_r) ? t_mid : n_r;
        k_nxt     = base_r;
        state_nxt = iul_pkg::B_LDA;
      end
      iul_pkg::B_LDA: begin
        raddr     = a_r;
        state_nxt = iul_pkg::B_LDB;
      end
      iul_pkg::B_LDB: begin
        head_a_nxt = rd_data;
        raddr      = b_r;
        state_nxt  = iul_pkg::B_CAPB;
      end
      iul_pkg::B_CAPB: begin
        head_b_nxt = rd_data;
        state_nxt  = iul_pkg::B_MERGE;
      end
      iul_pkg::B_MERGE: begin
        if (!ha_v && !hb_v) begin
          if (next_base >= n_r) begin
            run_nxt  = run_r << 1;
            src_nxt  = !src_r;
            base_nxt = '0;
            i_nxt    = '0;
            state_nxt = ((run_r << 1) >= n_r) ? iul_pkg::B_SWRD : iul_pkg::B_BLK;
          end else begin
            base_nxt  = next_base;
            state_nxt = iul_pkg::B_BLK;
          end
        end else begin
          wr_en = 1'b1;
          k_nxt = k_r + 1'b1;
          if (take_a) begin
            a_nxt     = a_r + 1'b1;
            raddr     = a_r + 1'b1;
            state_nxt = iul_pkg::B_WAITA;
          end else begin
            b_nxt     = b_r + 1'b1;
            raddr     = b_r + 1'b1;
            state_nxt = iul_pkg::B_WAITB;
          end
        end
      end
      iul_pkg::B_WAITA: begin
        head_a_nxt = rd_data;
        state_nxt  = iul_pkg::B_MERGE;
      end
      iul_pkg::B_WAITB: begin
        head_b_nxt = rd_data;
        state_nxt  = iul_pkg::B_MERGE;
      end
      iul_pkg::B_SWRD: begin
        raddr     = i_r;
        state_nxt = (i_r < n_r) ? iul_pkg::B_SWEX : iul_pkg::B_OUT;
      end
      iul_pkg::B_SWEX: begin
        // reversed intervals are skipped; extensions past the covered point add
        if (hi >= lo) begin
          if (lo < cov_r) begin
            if (hi > cov_r) begin
              sum_nxt = sum_r + LB'(hi - cov_r);
              cov_nxt = hi;
            end
          end else begin
            sum_nxt = sum_r + LB'(hi - lo);
            cov_nxt = hi;
          end
        end
        i_nxt     = i_r + 1'b1;
        state_nxt = iul_pkg::B_SWRD;
      end
      iul_pkg::B_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = sum_r;
          out_ovf_nxt   = ovf_r;
          set_done      = 1'b1;
          state_nxt     = iul_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = iul_pkg::B_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iul_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    run_r     <= run_nxt;
    base_r    <= base_nxt;
    mid_r     <= mid_nxt;
    end_r     <= end_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    k_r       <= k_nxt;
    i_r       <= i_nxt;
    src_r     <= src_nxt;
    ovf_r     <= ovf_nxt;
    head_a_r  <= head_a_nxt;
    head_b_r  <= head_b_nxt;
    cov_r     <= cov_nxt;
    sum_r     <= sum_nxt;
    out_len_r <= out_len_nxt;
    out_ovf_r <= out_ovf_nxt;
  end
endmodule

>>> sv/iul_checker.sv
// port-level checker for the interval union length block, with its bind
`timescale 1ns / 1ps
module iul_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_is_last,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [iul_pkg::LEN_BITS-1:0] out_len
);
  // a stalled result keeps its length
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_len))
    else $error("result changed while stalled");

  // closing a set stops intake until the result is built
  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_is_last |=> !in_ready)
    else $error("input accepted right after last transaction");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind interval_union_length_top iul_checker u_iul_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .in_is_last (in_chan.is_last),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_len    (out_chan.union_length)
);
